/* sv/cbc_pkg.sv */
// Cartridge bank controller package: widths, codes and shared types.
// No dependencies; every other file of the block depends on it.
`default_nettype none

package cbc_pkg;

  // Bank register widths
  localparam int ROM_BANK_BITS = 5;
  localparam int RAM_BANK_BITS = 2;

  // Bus and physical address widths
  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int ROM_ADDR_W   = 19;
  localparam int RAM_ADDR_W   = 15;
  localparam int ROM_WIN_BITS = 14;  // 16 KiB switchable ROM window
  localparam int RAM_WIN_BITS = 13;  // 8 KiB cartridge RAM window
  localparam int REGION_W     = 3;   // address bits [15:13]

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_BACKED = 2'd2;

  // 8 KiB regions of the cpu bus
  localparam logic [REGION_W-1:0] REGION_RAM_ENABLE = 3'b000;
  localparam logic [REGION_W-1:0] REGION_ROM_BANK   = 3'b001;
  localparam logic [REGION_W-1:0] REGION_RAM_BANK   = 3'b010;
  localparam logic [REGION_W-1:0] REGION_MODE       = 3'b011;
  localparam logic [REGION_W-1:0] REGION_CART_RAM   = 3'b101;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  // Result target codes
  localparam int TARGET_W = 3;
  typedef enum logic [TARGET_W-1:0] {
    TGT_ROM_READ  = 3'd0,
    TGT_RAM_READ  = 3'd1,
    TGT_RAM_WRITE = 3'd2,
    TGT_OPEN_BUS  = 3'd3,
    TGT_NONE      = 3'd4
  } target_t;

  // Access kind
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [TARGET_W-1:0]   target;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [RAM_ADDR_W-1:0] ram_address;
    logic [DATA_W-1:0]     ram_data;
    logic                  save_pending;
  } result_t;

  typedef struct packed {
    logic mapper_enabled;
    logic ram_present;
    logic battery_backed;
  } cfg_t;

  typedef struct packed {
    logic                     en;
    logic [CFG_IDX_W-1:0]     index;
    logic [CFG_DATA_W-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic                     ram_enable;
    logic [ROM_BANK_BITS-1:0] rom_bank;
    logic [RAM_BANK_BITS-1:0] ram_bank_value;
    logic                     banking_mode;
    logic [RAM_BANK_BITS-1:0] active_ram_bank;
    logic                     save_flag;
  } bank_state_t;

endpackage

`default_nettype wire

/* sv/cbc_if.sv */
// Valid/ready channel interfaces for bus accesses, results and configuration.
// Depends on cbc_pkg for the field widths.
`default_nettype none

interface cbc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [cbc_pkg::ADDR_W-1:0] address;
  logic [cbc_pkg::DATA_W-1:0] write_data;

  modport source (output valid, kind, address, write_data, input ready);
  modport sink   (input valid, kind, address, write_data, output ready);
endinterface

interface cbc_out_if;
  logic                           valid;
  logic                           ready;
  logic [cbc_pkg::TARGET_W-1:0]   target;
  logic [cbc_pkg::ROM_ADDR_W-1:0] rom_address;
  logic [cbc_pkg::RAM_ADDR_W-1:0] ram_address;
  logic [cbc_pkg::DATA_W-1:0]     ram_data;
  logic                           save_pending;

  modport source (output valid, target, rom_address, ram_address, ram_data,
                  save_pending, input ready);
  modport sink   (input valid, target, rom_address, ram_address, ram_data,
                  save_pending, output ready);
endinterface

interface cbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cbc_pkg::CFG_IDX_W-1:0]  index;
  logic [cbc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/cbc_decode.sv */
// Access decoder: maps one bus transaction onto ROM, RAM or bank registers.
// Purely combinational; depends on cbc_pkg.
`default_nettype none

module cbc_decode (
  input  cbc_pkg::item_t       item,
  input  cbc_pkg::cfg_t        cfg,
  input  cbc_pkg::bank_state_t state,
  output cbc_pkg::result_t     result,
  output cbc_pkg::bank_state_t state_nxt
);
  import cbc_pkg::*;

  logic [REGION_W-1:0]      region;
  logic [ROM_BANK_BITS-1:0] rom_sel;
  logic [RAM_BANK_BITS-1:0] ram_sel;
  logic                     ram_ok;
  logic [ROM_ADDR_W-1:0]    rom_linear;
  logic [ROM_ADDR_W-1:0]    rom_banked;
  logic [RAM_ADDR_W-1:0]    ram_phys;
  target_t                  tgt;

  assign region  = item.address[ADDR_W-1 -: REGION_W];
  assign rom_sel = item.write_data[ROM_BANK_BITS-1:0];
  assign ram_sel = item.write_data[RAM_BANK_BITS-1:0];
  assign ram_ok  = state.ram_enable & cfg.ram_present;

  // Physical addresses: bank number on top of the window offset
  assign rom_linear = ROM_ADDR_W'(item.address);
  assign rom_banked = ROM_ADDR_W'({state.rom_bank, item.address[ROM_WIN_BITS-1:0]});
  assign ram_phys   = RAM_ADDR_W'({state.active_ram_bank, item.address[RAM_WIN_BITS-1:0]});

  always_comb begin
    state_nxt           = state;
    tgt                 = TGT_NONE;
    result.rom_address  = '0;
    result.ram_address  = '0;
    result.ram_data     = '0;

    if (item.kind == KIND_READ) begin
      // Reads: fixed bank, cart RAM, switchable bank, else open bus
      if (!cfg.mapper_enabled || item.address[ADDR_W-1 -: 2] == 2'b00) begin
        tgt                = TGT_ROM_READ;
        result.rom_address = rom_linear;
      end else if (region == REGION_CART_RAM) begin
        if (ram_ok) begin
          tgt                = TGT_RAM_READ;
          result.ram_address = ram_phys;
        end else begin
          tgt = TGT_OPEN_BUS;
        end
      end else if (!item.address[ADDR_W-1]) begin
        tgt                = TGT_ROM_READ;
        result.rom_address = rom_banked;
      end else begin
        tgt = TGT_OPEN_BUS;
      end
    end else if (cfg.mapper_enabled) begin
      // Writes: bank register programming or RAM store
      case (region)
        REGION_RAM_ENABLE: begin
          state_nxt.ram_enable = (item.write_data[3:0] == RAM_ENABLE_KEY);
        end
        REGION_ROM_BANK: begin
          state_nxt.rom_bank = (rom_sel == '0) ? ROM_BANK_BITS'(1) : rom_sel;
        end
        REGION_RAM_BANK: begin
          state_nxt.ram_bank_value = ram_sel;
          if (state.banking_mode) state_nxt.active_ram_bank = ram_sel;
        end
        REGION_MODE: begin
          state_nxt.banking_mode = item.write_data[0];
          if (item.write_data[0]) state_nxt.active_ram_bank = state.ram_bank_value;
        end
        REGION_CART_RAM: begin
          if (ram_ok) begin
            tgt                = TGT_RAM_WRITE;
            result.ram_address = ram_phys;
            result.ram_data    = item.write_data;
            if (cfg.battery_backed) state_nxt.save_flag = 1'b1;
          end
        end
        default: begin
          tgt = TGT_NONE;
        end
      endcase
    end

    result.target       = tgt;
    result.save_pending = state_nxt.save_flag;
  end

endmodule

`default_nettype wire

/* sv/cbc_bank_regs.sv */
// Configuration and bank state registers of the cartridge bank controller.
// Depends on cbc_pkg.
`default_nettype none

module cbc_bank_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cbc_pkg::cfg_wr_t     cfg_wr,
  input  logic                 upd_en,
  input  cbc_pkg::bank_state_t state_nxt,
  output cbc_pkg::cfg_t        cfg,
  output cbc_pkg::bank_state_t state
);
  import cbc_pkg::*;

  cfg_t        cfg_r;
  bank_state_t state_r;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mapper_enabled <= 1'b1;
      cfg_r.ram_present    <= 1'b1;
      cfg_r.battery_backed <= 1'b0;
    end else if (cfg_wr.en) begin
      case (cfg_wr.index)
        CFG_MAPPER_ENABLED: cfg_r.mapper_enabled <= cfg_wr.data[0];
        CFG_RAM_PRESENT:    cfg_r.ram_present    <= cfg_wr.data[0];
        CFG_BATTERY_BACKED: cfg_r.battery_backed <= cfg_wr.data[0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  // Bank state, updated as each transaction completes decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.ram_enable      <= 1'b0;
      state_r.rom_bank        <= ROM_BANK_BITS'(1);
      state_r.ram_bank_value  <= '0;
      state_r.banking_mode    <= 1'b0;
      state_r.active_ram_bank <= '0;
      state_r.save_flag       <= 1'b0;
    end else if (upd_en) begin
      state_r <= state_nxt;
    end
  end

  assign cfg   = cfg_r;
  assign state = state_r;

  // ROM bank zero is never selectable
  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.rom_bank != '0)
    else $error("ROM bank register holds zero");

  // Save flag stays set until reset
  a_save_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.save_flag |=> state_r.save_flag)
    else $error("save flag cleared without reset");

  // In mode 1 the active RAM bank tracks the bank value
  a_mode1_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.banking_mode |-> state_r.active_ram_bank == state_r.ram_bank_value)
    else $error("active RAM bank differs from bank value in mode 1");

endmodule

`default_nettype wire

/* sv/cart_bank_controller.sv */
// Cartridge bank controller: one bus access in, one result out.
// Each transaction passes an input register, then decode into the result register;
// throughput one transaction per cycle while the result channel is not stalled.
// Bank state advances as each access passes decode. Synchronous active-low
// reset restores defaults: mapper on, RAM present, no battery, ROM bank 1.
// Depends on cbc_pkg, cbc_if, cbc_decode and cbc_bank_regs.
`default_nettype none

module cart_bank_controller (
  input  logic      clk,
  input  logic      rst_n,
  cbc_in_if.sink    in_chan,
  cbc_out_if.source out_chan,
  cbc_cfg_if.sink   cfg_chan
);
  import cbc_pkg::*;

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  result_t     out_res_r;
  logic        advance;
  logic        in_fire;
  cfg_wr_t     cfg_wr;
  cfg_t        cfg;
  bank_state_t state;
  bank_state_t state_nxt;
  result_t     result;

  // Handshake control: decode moves whenever the result register can take it
  assign advance       = s1_valid_r & (~out_valid_r | out_chan.ready);
  assign in_chan.ready = ~s1_valid_r | advance;
  assign in_fire       = in_chan.valid & in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign cfg_wr.en    = cfg_chan.valid;
  assign cfg_wr.index = cfg_chan.index;
  assign cfg_wr.data  = cfg_chan.data;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.kind       <= in_chan.kind;
      s1_item_r.address    <= in_chan.address;
      s1_item_r.write_data <= in_chan.write_data;
    end
  end

  cbc_bank_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .upd_en    (advance),
    .state_nxt (state_nxt),
    .cfg       (cfg),
    .state     (state)
  );

  cbc_decode u_decode (
    .item      (s1_item_r),
    .cfg       (cfg),
    .state     (state),
    .result    (result),
    .state_nxt (state_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.target       = out_res_r.target;
  assign out_chan.rom_address  = out_res_r.rom_address;
  assign out_chan.ram_address  = out_res_r.ram_address;
  assign out_chan.ram_data     = out_res_r.ram_data;
  assign out_chan.save_pending = out_res_r.save_pending;

  // A decoded transaction always lands in the result register
  a_decode_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("decoded transaction did not reach the result register");

  // A held input transaction is not dropped while the output stalls
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled input transaction lost");

endmodule

`default_nettype wire

/* test/cbc_checker.sv */
// Scoreboard for the cartridge bank controller: tracks the bank registers and
// configuration, predicts each result and compares it with what the block returns.
// Depends on cbc_pkg and the channel interfaces of cbc_if.
module cbc_checker (
  input  logic clk,
  input  logic rst_n,
  cbc_in_if    in_mon,
  cbc_out_if   out_mon,
  cbc_cfg_if   cfg_mon,
  output int   fail_count,
  output int   outstanding
);
  import cbc_pkg::*;

  // keep the log short when something goes badly wrong
  localparam int MAX_REPORTS = 40;

  cfg_t        cart_cfg;
  bank_state_t banks;
  result_t     expected_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report(input string msg);
    if (fail_count < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Decode one bus access against the tracked bank state; register writes
  // update that state as a side effect
  function automatic result_t predict_access(input item_t acc);
    result_t             r;
    logic [REGION_W-1:0] region;
    r        = '0;
    r.target = TGT_NONE;
    region   = acc.address[ADDR_W-1 -: REGION_W];
    if (acc.kind == KIND_READ) begin
      if (!cart_cfg.mapper_enabled || acc.address < 16'h4000) begin
        r.target      = TGT_ROM_READ;
        r.rom_address = ROM_ADDR_W'(acc.address);
      end else if (region == REGION_CART_RAM) begin
        if (banks.ram_enable && cart_cfg.ram_present) begin
          r.target      = TGT_RAM_READ;
          r.ram_address = {banks.active_ram_bank, acc.address[RAM_WIN_BITS-1:0]};
        end else begin
          r.target = TGT_OPEN_BUS;
        end
      end else if (acc.address < 16'h8000) begin
        r.target      = TGT_ROM_READ;
        r.rom_address = {banks.rom_bank, acc.address[ROM_WIN_BITS-1:0]};
      end else begin
        r.target = TGT_OPEN_BUS;
      end
    end else if (cart_cfg.mapper_enabled) begin
      case (region)
        REGION_RAM_ENABLE: begin
          banks.ram_enable = (acc.write_data[3:0] == RAM_ENABLE_KEY);
        end
        REGION_ROM_BANK: begin
          // mask first, then bank 0 is promoted to bank 1
          banks.rom_bank = acc.write_data[ROM_BANK_BITS-1:0];
          if (banks.rom_bank == '0) banks.rom_bank = ROM_BANK_BITS'(1);
        end
        REGION_RAM_BANK: begin
          banks.ram_bank_value = acc.write_data[RAM_BANK_BITS-1:0];
          if (banks.banking_mode) banks.active_ram_bank = banks.ram_bank_value;
        end
        REGION_MODE: begin
          banks.banking_mode = acc.write_data[0];
          if (banks.banking_mode) banks.active_ram_bank = banks.ram_bank_value;
        end
        REGION_CART_RAM: begin
          if (banks.ram_enable && cart_cfg.ram_present) begin
            r.target      = TGT_RAM_WRITE;
            r.ram_address = {banks.active_ram_bank, acc.address[RAM_WIN_BITS-1:0]};
            r.ram_data    = acc.write_data;
            if (cart_cfg.battery_backed) banks.save_flag = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.save_pending = banks.save_flag;
    return r;
  endfunction

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    item_t   acc;
    result_t got;
    result_t want;
    if (!rst_n) begin
      cart_cfg                = '0;
      cart_cfg.mapper_enabled = 1'b1;
      cart_cfg.ram_present    = 1'b1;
      banks                   = '0;
      banks.rom_bank          = ROM_BANK_BITS'(1);
      expected_q.delete();
    end else begin
      // configuration transaction: only bit 0 counts, unknown indexes ignored
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_MAPPER_ENABLED: cart_cfg.mapper_enabled = cfg_mon.data[0];
          CFG_RAM_PRESENT:    cart_cfg.ram_present    = cfg_mon.data[0];
          CFG_BATTERY_BACKED: cart_cfg.battery_backed = cfg_mon.data[0];
          default: ;
        endcase
      end
      // bus access transaction
      if (in_mon.valid && in_mon.ready) begin
        acc.kind       = in_mon.kind;
        acc.address    = in_mon.address;
        acc.write_data = in_mon.write_data;
        expected_q.push_back(predict_access(acc));
      end
      // result transaction
      if (out_mon.valid && out_mon.ready) begin
        got.target       = out_mon.target;
        got.rom_address  = out_mon.rom_address;
        got.ram_address  = out_mon.ram_address;
        got.ram_data     = out_mon.ram_data;
        got.save_pending = out_mon.save_pending;
        if (expected_q.size() == 0) begin
          report($sformatf("result with nothing outstanding, target %0d", got.target));
        end else begin
          want = expected_q.pop_front();
          if (got.target !== want.target)
            report($sformatf("target got %0d want %0d", got.target, want.target));
          if (got.rom_address !== want.rom_address)
            report($sformatf("rom_address got %h want %h", got.rom_address,
                             want.rom_address));
          if (got.ram_address !== want.ram_address)
            report($sformatf("ram_address got %h want %h", got.ram_address,
                             want.ram_address));
          if (got.ram_data !== want.ram_data)
            report($sformatf("ram_data got %h want %h", got.ram_data, want.ram_data));
          if (got.save_pending !== want.save_pending)
            report($sformatf("save_pending got %b want %b", got.save_pending,
                             want.save_pending));
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

/* test/tb_cart_bank_controller.sv */
// Top of the cartridge bank controller testbench: clock, reset, directed and
// random bus accesses, configuration phases, result back-pressure and verdict.
// Depends on cbc_pkg, cbc_if, cart_bank_controller and cbc_checker.
module tb_cart_bank_controller;
  import cbc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 150;
  localparam int PHASE_ITEMS = 160;
  localparam int NUM_PHASES  = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // cartridge settings per phase: {mapper_enabled, ram_present, battery_backed}
  localparam cfg_t PHASE_PLAN [NUM_PHASES] =
    '{3'b111, 3'b101, 3'b011, 3'b000, 3'b110, 3'b111};

  logic clk        = 1'b0;
  logic rst_n;
  logic tx_gaps_on = 1'b1;
  logic rx_gaps_on = 1'b1;
  logic hold_req   = 1'b0;
  int   fail_count;
  int   outstanding;
  int   cycle_count;

  cbc_in_if  acc_bus();
  cbc_out_if res_bus();
  cbc_cfg_if cfg_bus();

  cart_bank_controller uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (acc_bus),
    .out_chan (res_bus),
    .cfg_chan (cfg_bus)
  );

  cbc_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (acc_bus),
    .out_mon     (res_bus),
    .cfg_mon     (cfg_bus),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Mostly back-to-back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Random access, biased towards the register and RAM windows
  function automatic item_t random_access();
    item_t       a;
    int unsigned pick;
    a.kind       = 1'($urandom_range(0, 1));
    a.address    = 16'($urandom);
    a.write_data = 8'($urandom);
    pick         = $urandom_range(0, 99);
    if (pick < 12) begin
      a.kind    = KIND_WRITE;
      a.address = {REGION_RAM_ENABLE, 13'($urandom)};
      if ($urandom_range(0, 2) != 0) a.write_data[3:0] = RAM_ENABLE_KEY;
    end else if (pick < 22) begin
      a.kind    = KIND_WRITE;
      a.address = {REGION_ROM_BANK, 13'($urandom)};
      if ($urandom_range(0, 5) == 0) a.write_data[ROM_BANK_BITS-1:0] = '0;
    end else if (pick < 30) begin
      a.kind    = KIND_WRITE;
      a.address = {REGION_RAM_BANK, 13'($urandom)};
    end else if (pick < 36) begin
      a.kind    = KIND_WRITE;
      a.address = {REGION_MODE, 13'($urandom)};
    end else if (pick < 66) begin
      a.address = {REGION_CART_RAM, 13'($urandom)};
    end else if (pick < 86) begin
      a.kind        = KIND_READ;
      a.address[15] = 1'b0;
    end
    return a;
  endfunction

  // One access transaction, preceded by an optional idle gap
  task automatic send_access(input logic kind, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    int n;
    n = tx_gaps_on ? pick_gap() : 0;
    if (n > 0) begin
      @(negedge clk);
      acc_bus.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    acc_bus.valid      <= 1'b1;
    acc_bus.kind       <= kind;
    acc_bus.address    <= addr;
    acc_bus.write_data <= data;
    do @(posedge clk); while (acc_bus.ready !== 1'b1);
  endtask

  // Stop offering and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk);
    acc_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Program the cartridge type; upper data bits are junk and must be ignored
  task automatic set_cart(input cfg_t c);
    write_reg(CFG_BATTERY_BACKED, {7'($urandom), c.battery_backed});
    write_reg(CFG_UNMAPPED, 8'($urandom));
    write_reg(CFG_MAPPER_ENABLED, {7'($urandom), c.mapper_enabled});
    write_reg(CFG_RAM_PRESENT, {7'($urandom), c.ram_present});
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        n = rx_gaps_on ? pick_gap() : 0;
        if (n > 0) begin
          res_bus.ready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end else begin
          res_bus.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count, outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus
  initial begin
    item_t acc;
    rst_n              = 1'b0;
    acc_bus.valid      = 1'b0;
    acc_bus.kind       = KIND_READ;
    acc_bus.address    = '0;
    acc_bus.write_data = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_MAPPER_ENABLED;
    cfg_bus.data       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: mapper on, RAM present, no battery
    send_access(KIND_READ,  16'h0000, 8'h00);  // fixed ROM bank, both ends
    send_access(KIND_READ,  16'h3FFF, 8'hFF);
    send_access(KIND_READ,  16'h4000, 8'h00);  // switchable bank at reset
    send_access(KIND_READ,  16'h7FFF, 8'h00);
    send_access(KIND_READ,  16'hA000, 8'h00);  // RAM still disabled
    send_access(KIND_WRITE, 16'hB000, 8'h5A);
    send_access(KIND_WRITE, 16'h0000, 8'h1A);  // enable key with high bits set
    send_access(KIND_READ,  16'hBFFF, 8'h00);
    send_access(KIND_WRITE, 16'h2000, 8'h00);  // bank 0 becomes bank 1
    send_access(KIND_WRITE, 16'h3FFF, 8'hE0);  // masks to zero, then 1
    send_access(KIND_READ,  16'h4123, 8'h00);
    send_access(KIND_WRITE, 16'h2000, 8'hFF);  // top ROM bank
    send_access(KIND_READ,  16'h7FFF, 8'h00);
    send_access(KIND_WRITE, 16'h4000, 8'hFF);  // bank value, mode 0 keeps bank 0
    send_access(KIND_WRITE, 16'hA123, 8'hFF);
    send_access(KIND_WRITE, 16'h6000, 8'hFF);  // mode 1 picks up the bank value
    send_access(KIND_WRITE, 16'hBFFF, 8'h00);
    send_access(KIND_READ,  16'h8000, 8'h00);  // outside cartridge space
    send_access(KIND_READ,  16'hFFFF, 8'h00);
    send_access(KIND_WRITE, 16'hC000, 8'h55);
    send_access(KIND_WRITE, 16'h9FFF, 8'hAA);
    send_access(KIND_WRITE, 16'h6000, 8'hFE);  // mode 0 leaves active bank alone
    send_access(KIND_WRITE, 16'h5FFF, 8'h01);
    send_access(KIND_WRITE, 16'h1FFF, 8'h0B);  // wrong key disables RAM
    send_access(KIND_READ,  16'hA000, 8'h00);

    // Random part, one cartridge setting per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      set_cart(PHASE_PLAN[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) begin
          tx_gaps_on = ($urandom_range(0, 3) != 0);
          rx_gaps_on = ($urandom_range(0, 3) != 0);
        end
        // back-pressure burst: results held off while accesses keep coming
        if ((p == 1 || p == 4) && i == 40) begin
          hold_req   = 1'b1;
          tx_gaps_on = 1'b0;
        end
        if (i == PHASE_ITEMS / 2) wait_drained();
        acc = random_access();
        send_access(acc.kind, acc.address, acc.write_data);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/cbc_pkg.sv
sv/cbc_if.sv
sv/cbc_decode.sv
sv/cbc_bank_regs.sv
sv/cart_bank_controller.sv
test/cbc_checker.sv
test/tb_cart_bank_controller.sv
